// ===== hw/rtl/urlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, character codes and helper functions of the URL decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  typedef struct packed {
    logic [1:0]                 count;
    logic [MaxResults-1:0][7:0] bytes;
    logic                       last;
    logic [1:0]                 phase_d;
    logic [7:0]                 held_d;
  } step_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic on_safe_list(input logic [7:0] v);
    logic r;
    r = 1'b0;
    if (v >= 8'd48 && v <= 8'd57) begin
      r = 1'b1;
    end else if (v >= 8'd97 && v <= 8'd122) begin
      r = 1'b1;
    end else if (v >= 8'd65 && v <= 8'd90) begin
      r = 1'b1;
    end else begin
      case (v)
        8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h3a, 8'h3b, 8'h3d, 8'h3f, 8'h40, 8'h5f: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/urlpd_in_if.sv =====
// ----------------------------------------------------------------------------
// urlpd_in_if
// Encoded byte channel: one character per beat with an end-of-string flag.
// ----------------------------------------------------------------------------
interface urlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/urlpd_out_if.sv =====
// ----------------------------------------------------------------------------
// urlpd_out_if
// Decoded byte channel: one character per beat with an end-of-string flag.
// ----------------------------------------------------------------------------
interface urlpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/urlpd_step.sv =====
// ----------------------------------------------------------------------------
// urlpd_step
// Next-state and result group for one encoded byte, given the pending state.
// ----------------------------------------------------------------------------
module urlpd_step (
  input  logic [1:0]       phase_i,
  input  logic [7:0]       held_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output urlpd_pkg::step_t step_o
);

  logic [4:0] hex_b;
  logic [4:0] hex_h;
  logic [7:0] value;
  logic       is_pct;
  logic [7:0] plain_byte;

  assign hex_b      = urlpd_pkg::hex_val(byte_i);
  assign hex_h      = urlpd_pkg::hex_val(held_i);
  assign value      = {(hex_h[4] ? hex_h[3:0] : 4'd0), hex_b[3:0]};
  assign is_pct     = (byte_i == urlpd_pkg::CH_PERCENT);
  assign plain_byte = (byte_i == urlpd_pkg::CH_PLUS) ? urlpd_pkg::CH_SPACE : byte_i;

  always_comb begin
    step_o         = '0;
    step_o.held_d  = held_i;
    step_o.phase_d = urlpd_pkg::PH_IDLE;
    step_o.last    = last_i;

    unique case (phase_i)
      urlpd_pkg::PH_PCT: begin
        if (hex_b[4]) begin
          step_o.held_d  = byte_i;
          step_o.phase_d = urlpd_pkg::PH_DIGIT;
        end else begin
          step_o.bytes[0] = urlpd_pkg::CH_PERCENT;
          if (is_pct) begin
            step_o.phase_d = urlpd_pkg::PH_PCT;
            step_o.count   = 2'd1;
          end else begin
            step_o.bytes[1] = plain_byte;
            step_o.count    = 2'd2;
          end
        end
      end
      urlpd_pkg::PH_DIGIT: begin
        if (hex_b[4]) begin
          if (!urlpd_pkg::on_safe_list(value)) begin
            step_o.bytes[0] = value;
            step_o.count    = 2'd1;
          end else begin
            step_o.bytes[0] = urlpd_pkg::CH_PERCENT;
            step_o.bytes[1] = held_i;
            step_o.bytes[2] = byte_i;
            step_o.count    = 2'd3;
          end
        end else begin
          step_o.bytes[0] = urlpd_pkg::CH_PERCENT;
          step_o.bytes[1] = held_i;
          if (is_pct) begin
            step_o.phase_d = urlpd_pkg::PH_PCT;
            step_o.count   = 2'd2;
          end else begin
            step_o.bytes[2] = plain_byte;
            step_o.count    = 2'd3;
          end
        end
      end
      default: begin
        if (is_pct) begin
          step_o.phase_d = urlpd_pkg::PH_PCT;
        end else begin
          step_o.bytes[0] = plain_byte;
          step_o.count    = 2'd1;
        end
      end
    endcase

    // end of string flushes whatever is pending
    if (last_i) begin
      if (step_o.phase_d == urlpd_pkg::PH_PCT) begin
        if (step_o.count == 2'd0) begin
          step_o.bytes[0] = urlpd_pkg::CH_PERCENT;
        end else if (step_o.count == 2'd1) begin
          step_o.bytes[1] = urlpd_pkg::CH_PERCENT;
        end else begin
          step_o.bytes[2] = urlpd_pkg::CH_PERCENT;
        end
        step_o.count = step_o.count + 2'd1;
      end else if (step_o.phase_d == urlpd_pkg::PH_DIGIT) begin
        step_o.bytes[0] = urlpd_pkg::CH_PERCENT;
        step_o.bytes[1] = step_o.held_d;
        step_o.count    = 2'd2;
      end
      step_o.phase_d = urlpd_pkg::PH_IDLE;
    end
  end

endmodule

// ===== hw/rtl/url_percent_decoder_safe_chars_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_safe_chars_core
// Streaming URL decoder: plus to space, percent escapes of unsafe bytes decoded.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle while in_i.ready is high; its decoded
// bytes appear in the next cycle from a result register. Each input yields
// zero to three output bytes; the output port moves one byte per beat, so an
// input that yields two or three bytes holds in_i.ready low while the result
// register drains; otherwise one byte per cycle flows while out_o.ready is set.
// A percent escape whose value is a letter, digit or safe punctuation mark is
// left encoded. out_last marks the final decoded byte of each string; a string
// end with nothing to emit produces no beat.
module url_percent_decoder_safe_chars_core (
  input  logic clk_i,
  input  logic rst_ni,
  urlpd_in_if.sink    in_i,
  urlpd_out_if.source out_o
);

  logic [1:0] phase_q;
  logic [7:0] held_q;

  logic                                      grp_valid_q;
  logic [1:0]                                grp_cnt_q;
  logic [1:0]                                grp_idx_q;
  logic [urlpd_pkg::MaxResults-1:0][7:0]     grp_bytes_q;
  logic                                      grp_last_q;

  urlpd_pkg::step_t step;
  logic             in_fire;
  logic             out_fire;
  logic             grp_final;

  urlpd_step u_step (
    .phase_i (phase_q),
    .held_i  (held_q),
    .byte_i  (in_i.in_byte),
    .last_i  (in_i.in_last),
    .step_o  (step)
  );

  assign grp_final   = (grp_idx_q == grp_cnt_q - 2'd1);
  assign out_fire    = out_o.valid && out_o.ready;
  assign in_i.ready  = !grp_valid_q || (out_o.ready && grp_final);
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid    = grp_valid_q;
  assign out_o.out_byte = grp_bytes_q[grp_idx_q];
  assign out_o.out_last = grp_last_q && grp_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= urlpd_pkg::PH_IDLE;
      held_q      <= 8'd0;
      grp_valid_q <= 1'b0;
      grp_cnt_q   <= 2'd0;
      grp_idx_q   <= 2'd0;
    end else begin
      if (in_fire) begin
        phase_q     <= step.phase_d;
        held_q      <= step.held_d;
        grp_valid_q <= (step.count != 2'd0);
        grp_cnt_q   <= step.count;
        grp_idx_q   <= 2'd0;
      end else if (out_fire) begin
        if (grp_final) begin
          grp_valid_q <= 1'b0;
        end else begin
          grp_idx_q <= grp_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      grp_bytes_q <= step.bytes;
      grp_last_q  <= step.last;
    end
  end

  // a held group always has a byte left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_cnt_q != 2'd0) && (grp_idx_q < grp_cnt_q))
    else $error("result group index out of range");

  // end of string leaves nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.in_last) |=> (phase_q == urlpd_pkg::PH_IDLE))
    else $error("escape left pending after last byte");

  // a pending digit is always a hex digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == urlpd_pkg::PH_DIGIT) |-> urlpd_pkg::hex_val(held_q) >= 5'd16)
    else $error("held digit is not hex");

  // a stalled result keeps its position in the group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_valid_q && !out_o.ready) |=> grp_valid_q && $stable(grp_idx_q))
    else $error("result group moved while stalled");

  // no new beat is taken while an earlier group has more than its final byte left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_valid_q && !grp_final) |-> !in_i.ready)
    else $error("input taken with results outstanding");

endmodule
